// ===== design/mmf_pkg.sv =====
// Shared types and constants for the masked 3x3 median filter.
package mmf_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 4096;

  localparam int PIX_W    = 8;
  localparam int NTAPS    = 9;
  localparam int RANK_W   = 4;
  localparam int MASK_W   = 9;
  localparam int WCFG_W   = 11;
  localparam int HGT_W    = 13;
  localparam int CFG_W    = 13;
  localparam int CIDX_W   = 2;

  localparam logic [MASK_W-1:0] MASK_RESET   = 9'b010_111_010;
  localparam logic [WCFG_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [HGT_W-1:0]  HEIGHT_RESET = 13'd480;

  typedef enum logic [CIDX_W-1:0] {
    REG_MASK   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } cfg_reg_t;

  // One window handed to the median selector: taps in mask-bit order.
  typedef struct packed {
    logic [NTAPS-1:0]            kept;
    logic [NTAPS-1:0][PIX_W-1:0] smp;
    logic                        last;
  } win_item_t;

endpackage

// ===== design/mmf_rank_select.sv =====
// Two-stage rank-and-select median of up to nine kept window taps.
module mmf_rank_select (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  mmf_pkg::win_item_t       in_item,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [mmf_pkg::PIX_W-1:0] median_value,
  output logic                     last_of_frame
);
  import mmf_pkg::*;

  logic                         v2;
  win_item_t                    it2;
  logic                         v3;
  logic [NTAPS-1:0][PIX_W-1:0]  smp3;
  logic [NTAPS-1:0]             kept3;
  logic [NTAPS-1:0][RANK_W-1:0] rank3;
  logic [RANK_W-1:0]            half3;
  logic                         last3;

  logic [NTAPS-1:0][RANK_W-1:0] rank_next;
  logic [RANK_W-1:0]            count_next;
  logic [PIX_W-1:0]             median_next;
  logic                         out_free;
  logic                         s3_ready;

  assign out_free = !out_valid || out_ready;
  assign s3_ready = !v3 || out_free;
  assign in_ready = !v2 || s3_ready;

  // Rank of each kept tap among kept taps; ties broken by tap position.
  always_comb begin
    count_next = '0;
    for (int i = 0; i < NTAPS; i++) begin
      rank_next[i] = '0;
      if (it2.kept[i]) count_next = count_next + 1'b1;
      for (int j = 0; j < NTAPS; j++) begin
        if (j != i && it2.kept[j] &&
            (it2.smp[j] < it2.smp[i] || (it2.smp[j] == it2.smp[i] && j < i))) begin
          rank_next[i] = rank_next[i] + 1'b1;
        end
      end
    end
  end

  // Exactly one kept tap has rank count/2; none kept gives zero.
  always_comb begin
    median_next = '0;
    for (int i = 0; i < NTAPS; i++) begin
      if (kept3[i] && rank3[i] == half3) median_next = median_next | smp3[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) v2 <= in_valid;
      if (s3_ready) v3 <= v2;
      if (out_free) out_valid <= v3;
    end
    if (in_ready && in_valid) it2 <= in_item;
    if (s3_ready && v2) begin
      smp3  <= it2.smp;
      kept3 <= it2.kept;
      rank3 <= rank_next;
      half3 <= count_next >> 1;
      last3 <= it2.last;
    end
    if (out_free && v3) begin
      median_value  <= median_next;
      last_of_frame <= last3;
    end
  end

endmodule

// ===== design/masked_median_filter_3x3_core.sv =====
// Top level of the masked 3x3 median filter: line stores, window and frame counters.
//
// Pixels enter in raster order on the in_valid/in_ready channel; req_type high
// marks a flush item, which counts as a zero pixel. Results leave on the
// out_valid/out_ready channel, one per item once width+1 items of the frame
// are in, so the result for a pixel answers the item width+1 positions later.
// After the last pixel of a frame the host sends width+1 flush items; the
// result for the final pixel carries last_of_frame and the next item starts
// a new frame.
// Throughput is one item per clock unless a stalled receiver holds the input.
// A result for the item that releases it passes the line-store read, window
// and tap selection, then the rank stage and the select/output register.
// A stalled receiver fills the output register and the two selector stages;
// input then stops only when the item at the line-store stage must produce a
// result. Items with no result keep flowing.
// Reset clears all valid flags, the counters, the window and the registers
// (mask cross, width 640, height 480). Line stores are not cleared; entries
// never written only reach taps outside the image. Writing width or height
// restarts the frame; write configuration only while the block is idle.
module masked_median_filter_3x3_core #(
  parameter int MAX_WIDTH = mmf_pkg::MAX_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [mmf_pkg::CIDX_W-1:0] cfg_index,
  input  logic [mmf_pkg::CFG_W-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       req_type,
  input  logic [mmf_pkg::PIX_W-1:0]  pixel_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [mmf_pkg::PIX_W-1:0]  median_value,
  output logic                       last_of_frame
);
  import mmf_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
  localparam int PEND_W = $clog2(MAX_WIDTH + 2);

  // configuration
  logic [MASK_W-1:0]  nb_mask;
  logic [WCNT_W-1:0]  eff_w;
  logic [HGT_W-1:0]   eff_h;
  logic [WCFG_W-1:0]  cfg_w_raw;
  logic [HGT_W-1:0]   cfg_h_raw;
  logic               restart_cfg;

  // frame position
  logic [COL_W-1:0]   col;
  logic [HGT_W-1:0]   row;
  logic [PEND_W-1:0]  pending;

  // line stores
  logic [PIX_W-1:0]   upper_mem  [MAX_WIDTH];
  logic [PIX_W-1:0]   middle_mem [MAX_WIDTH];

  // line-store stage
  logic               v1;
  logic [PIX_W-1:0]   pix1;
  logic [COL_W-1:0]   addr1;
  logic [PIX_W-1:0]   rd_up;
  logic [PIX_W-1:0]   rd_mid;
  logic               prod1;
  logic [NTAPS-1:0]   keep1;
  logic               last1;

  logic [NTAPS-1:0][PIX_W-1:0] win;
  logic [NTAPS-1:0][PIX_W-1:0] win_sh;

  logic               accept;
  logic               s1_leave;
  logic               s1_wr;
  logic               fwd;
  logic               sel_ready;
  win_item_t          sel_item;

  logic               in_frame;
  logic [PIX_W-1:0]   v_in;
  logic               produce;
  logic [COL_W-1:0]   cx;
  logic [HGT_W-1:0]   cy;
  logic [WCNT_W-1:0]  cx_ext;
  logic [2:0]         row_ok;
  logic [2:0]         col_ok;
  logic [NTAPS-1:0]   keep_next;
  logic               last_next;

  logic [COL_W-1:0]   col_next;
  logic [HGT_W-1:0]   row_next;
  logic [PEND_W-1:0]  pending_next;

  // configuration
  assign cfg_w_raw   = cfg_data[WCFG_W-1:0];
  assign cfg_h_raw   = cfg_data[HGT_W-1:0];
  assign restart_cfg = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      nb_mask <= MASK_RESET;
      if (32'(WIDTH_RESET) > MAX_WIDTH) eff_w <= WCNT_W'(MAX_WIDTH);
      else                              eff_w <= WCNT_W'(WIDTH_RESET);
      eff_h <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MASK: begin
          nb_mask <= cfg_data[MASK_W-1:0];
        end
        REG_WIDTH: begin
          if (cfg_w_raw == '0)                   eff_w <= WCNT_W'(1);
          else if (32'(cfg_w_raw) > MAX_WIDTH)   eff_w <= WCNT_W'(MAX_WIDTH);
          else                                   eff_w <= WCNT_W'(cfg_w_raw);
        end
        REG_HEIGHT: begin
          if (cfg_h_raw == '0)                   eff_h <= HGT_W'(1);
          else if (32'(cfg_h_raw) > MAX_HEIGHT)  eff_h <= HGT_W'(MAX_HEIGHT);
          else                                   eff_h <= cfg_h_raw;
        end
        default: begin
        end
      endcase
    end
  end

  // handshake
  assign s1_leave = !prod1 || sel_ready;
  assign s1_wr    = v1 && s1_leave;
  assign in_ready = !v1 || s1_leave;
  assign accept   = in_valid && in_ready;
  // the item leaving now writes the address being read: take its values
  assign fwd      = s1_wr && (addr1 == col);

  // per-item position logic
  always_comb begin
    in_frame = row < eff_h;
    v_in     = (!req_type && in_frame) ? pixel_value : '0;
    produce  = pending >= (PEND_W'(eff_w) + 1'b1);
    if (col == '0) begin
      cx = COL_W'(eff_w - 1'b1);
      cy = (row >= HGT_W'(2)) ? row - HGT_W'(2) : '0;
    end else begin
      cx = col - 1'b1;
      cy = (row >= HGT_W'(1)) ? row - HGT_W'(1) : '0;
    end
    cx_ext = WCNT_W'(cx);
    // mask row 0 looks one row down, row 2 one row up (point reflection)
    row_ok[0] = (cy + 1'b1) < eff_h;
    row_ok[1] = cy < eff_h;
    row_ok[2] = (cy != '0) && (cy <= eff_h);
    col_ok[0] = (cx_ext + 1'b1) < eff_w;
    col_ok[1] = cx_ext < eff_w;
    col_ok[2] = (cx != '0) && (cx_ext <= eff_w);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        keep_next[r*3+c] = nb_mask[r*3+c] && row_ok[r] && col_ok[c];
      end
    end
    last_next = (cy == eff_h - 1'b1) && (cx_ext == eff_w - 1'b1);

    col_next     = col;
    row_next     = row;
    pending_next = pending;
    if (!produce) pending_next = pending + 1'b1;
    if ((WCNT_W'(col) + 1'b1) >= eff_w) begin
      col_next = '0;
      row_next = row + 1'b1;
    end else begin
      col_next = col + 1'b1;
    end
    if (produce && last_next) begin
      col_next     = '0;
      row_next     = '0;
      pending_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart_cfg) begin
      col     <= '0;
      row     <= '0;
      pending <= '0;
    end else if (accept) begin
      col     <= col_next;
      row     <= row_next;
      pending <= pending_next;
    end
  end

  // line stores: read at accept, write when the item leaves the stage
  always_ff @(posedge clk) begin
    if (s1_wr) upper_mem[addr1] <= rd_mid;
    if (accept) rd_up <= fwd ? rd_mid : upper_mem[col];
  end

  always_ff @(posedge clk) begin
    if (s1_wr) middle_mem[addr1] <= pix1;
    if (accept) rd_mid <= fwd ? pix1 : middle_mem[col];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_ready) begin
      v1 <= in_valid;
    end
    if (accept) begin
      pix1  <= v_in;
      addr1 <= col;
      prod1 <= produce;
      keep1 <= keep_next;
      last1 <= produce && last_next;
    end
  end

  // window shift: new column is (upper, middle, incoming)
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_sh[r*3+0] = win[r*3+1];
      win_sh[r*3+1] = win[r*3+2];
    end
    win_sh[2] = rd_up;
    win_sh[5] = rd_mid;
    win_sh[8] = pix1;
    for (int k = 0; k < NTAPS; k++) begin
      sel_item.smp[k]  = win_sh[NTAPS-1-k];
      sel_item.kept[k] = keep1[k] && (win_sh[NTAPS-1-k] != '0);
    end
    sel_item.last = last1;
  end

  always_ff @(posedge clk) begin
    if (rst || restart_cfg) begin
      win <= '0;
    end else if (s1_wr) begin
      win <= last1 ? '0 : win_sh;
    end
  end

  mmf_rank_select u_sel (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (v1 && prod1),
    .in_ready      (sel_ready),
    .in_item       (sel_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .median_value  (median_value),
    .last_of_frame (last_of_frame)
  );

endmodule

// ===== design/mmf_checker.sv =====
// Port-level checks for the masked 3x3 median filter, bound to the top level.
module mmf_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [mmf_pkg::PIX_W-1:0] median_value,
  input logic                      last_of_frame
);

  // a result waiting on the receiver holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(median_value) && $stable(last_of_frame))
    else $error("stalled result changed");

  // no result in the cycle after a reset edge
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // an empty output register never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // input keeps flowing while results are taken
  a_ready_drain: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while receiver ready");

endmodule

bind masked_median_filter_3x3_core mmf_checker u_mmf_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .median_value  (median_value),
  .last_of_frame (last_of_frame)
);

// ===== test/tb_top.sv =====
// Self-checking testbench for the masked 3x3 median filter core.
module tb_top;
  import mmf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic PIXEL_ITEM     = 1'b0;
  localparam logic FLUSH_ITEM     = 1'b1;
  localparam int   SETTLE_CYCLES  = 8;
  localparam int   WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    logic [PIX_W-1:0] median;
    logic             last;
  } median_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [CIDX_W-1:0]   cfg_index = REG_MASK;
  logic [CFG_W-1:0]    cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                req_type = PIXEL_ITEM;
  logic [PIX_W-1:0]    pixel_value = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [PIX_W-1:0]    median_value;
  logic                last_of_frame;

  masked_median_filter_3x3_core dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .pixel_value(pixel_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .median_value(median_value), .last_of_frame(last_of_frame)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Filter state mirrored for prediction
  logic [PIX_W-1:0]  upper_line [MAX_WIDTH_DEF];
  logic [PIX_W-1:0]  middle_line [MAX_WIDTH_DEF];
  logic [PIX_W-1:0]  win [3][3];
  int unsigned       col_pos, row_pos, owed_items;
  logic [MASK_W-1:0] mask_reg;
  logic [WCFG_W-1:0] width_reg;
  logic [HGT_W-1:0]  height_reg;

  median_result_t pending_medians [$];
  int error_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  function automatic int unsigned frame_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return int'(width_reg);
  endfunction

  function automatic int unsigned frame_height();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return int'(height_reg);
  endfunction

  function automatic void restart_frame();
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) win[r][c] = '0;
    col_pos = 0;
    row_pos = 0;
    owed_items = 0;
  endfunction

  function automatic void reset_filter_state();
    for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
      upper_line[i] = '0;
      middle_line[i] = '0;
    end
    mask_reg = MASK_RESET;
    width_reg = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    restart_frame();
  endfunction

  // Median of the masked, nonzero, in-image taps around (cy, cx)
  function automatic logic [PIX_W-1:0] window_median(int cy, int cx, int w, int h);
    logic [PIX_W-1:0] kept [9];
    logic [PIX_W-1:0] s;
    int n, k, ny, nx;
    n = 0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (!mask_reg[r*3+c]) continue;
        ny = cy + 1 - r;
        nx = cx + 1 - c;
        if (ny < 0 || ny >= h || nx < 0 || nx >= w) continue;
        s = win[2-r][2-c];
        if (s == 0) continue;
        k = n;
        while (k > 0 && kept[k-1] > s) begin
          kept[k] = kept[k-1];
          k--;
        end
        kept[k] = s;
        n++;
      end
    end
    if (n == 0) return '0;
    return kept[n/2];
  endfunction

  function automatic void predict_median(logic rt, logic [PIX_W-1:0] pv);
    int unsigned w, h, c, r, cx, cy;
    logic [PIX_W-1:0] v, up, mid;
    median_result_t res;
    bit frame_done;
    w = frame_width();
    h = frame_height();
    c = col_pos;
    r = row_pos;
    frame_done = 0;
    v = (rt == PIXEL_ITEM && r < h) ? pv : '0;
    up = upper_line[c];
    mid = middle_line[c];
    upper_line[c] = mid;
    middle_line[c] = v;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = up;
    win[1][2] = mid;
    win[2][2] = v;
    if (owed_items >= w + 1) begin
      // centre pixel trails the incoming item by width+1 positions
      if (c == 0) begin
        cx = w - 1;
        cy = (r >= 2) ? r - 2 : 0;
      end else begin
        cx = c - 1;
        cy = (r >= 1) ? r - 1 : 0;
      end
      res.median = window_median(cy, cx, w, h);
      res.last = (cy == h - 1) && (cx == w - 1);
      pending_medians.insert(pending_medians.size(), res);
      frame_done = res.last;
    end else begin
      owed_items++;
    end
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
    end
    if (frame_done) restart_frame();
  endfunction

  // Check results and drive out_ready
  always @(posedge clk) begin : result_check
    median_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_medians.size() == 0) begin
        if (error_count < 10)
          $display("unexpected result: median %0d last %0d", median_value, last_of_frame);
        error_count++;
      end else begin
        want = pending_medians.pop_front();
        if (want.median !== median_value || want.last !== last_of_frame) begin
          if (error_count < 10)
            $display("mismatch: expected median %0d last %0d, got median %0d last %0d",
                     want.median, want.last, median_value, last_of_frame);
          error_count++;
        end
      end
    end
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic send_item(input logic rt, input logic [PIX_W-1:0] pv);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    req_type <= rt;
    pixel_value <= pv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_median(rt, pv);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(value);
    @(posedge clk);
    case (idx)
      REG_MASK: mask_reg = MASK_W'(value);
      REG_WIDTH: begin
        width_reg = WCFG_W'(value);
        restart_frame();
      end
      REG_HEIGHT: begin
        height_reg = HGT_W'(value);
        restart_frame();
      end
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid, let every owed result arrive, then let the pipe settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(9))
      0, 1: return '0;
      2: return 8'hFF;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  function automatic int rand_mask();
    case ($urandom_range(9))
      0: return 0;
      1: return 511;
      2: return int'(MASK_RESET);
      default: return $urandom_range(511);
    endcase
  endfunction

  task automatic test_directed_frames();
    send_idle_pct = 0;
    stall_pct = 0;
    // full mask, 3x2 frame with zeros, a flush inside the frame, a pixel in the flush
    cfg_write(REG_MASK, 511);
    cfg_write(REG_WIDTH, 3);
    cfg_write(REG_HEIGHT, 2);
    send_item(PIXEL_ITEM, 8'd0);
    send_item(PIXEL_ITEM, 8'd255);
    send_item(PIXEL_ITEM, 8'd1);
    send_item(PIXEL_ITEM, 8'd128);
    send_item(FLUSH_ITEM, 8'hAA);
    send_item(PIXEL_ITEM, 8'd7);
    send_item(FLUSH_ITEM, 8'd0);
    send_item(PIXEL_ITEM, 8'd99);
    send_item(FLUSH_ITEM, 8'hFF);
    send_item(FLUSH_ITEM, 8'd0);
    wait_idle();
    // empty mask, zero width and height act as one
    cfg_write(REG_MASK, 0);
    cfg_write(REG_WIDTH, 0);
    cfg_write(REG_HEIGHT, 0);
    send_item(PIXEL_ITEM, 8'd255);
    send_item(FLUSH_ITEM, 8'd0);
    send_item(FLUSH_ITEM, 8'd0);
    wait_idle();
    // cross mask on a 2x2 frame
    cfg_write(REG_MASK, int'(MASK_RESET));
    cfg_write(REG_WIDTH, 2);
    cfg_write(REG_HEIGHT, 2);
    send_item(PIXEL_ITEM, 8'd10);
    send_item(PIXEL_ITEM, 8'd20);
    send_item(PIXEL_ITEM, 8'd30);
    send_item(PIXEL_ITEM, 8'd40);
    repeat (3) send_item(FLUSH_ITEM, 8'd0);
    wait_idle();
  endtask

  // Hold the output off for a long stretch while items keep coming
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    cfg_write(REG_MASK, 511);
    cfg_write(REG_WIDTH, 3);
    cfg_write(REG_HEIGHT, 8);
    hold_request = 300;
    for (int i = 0; i < 24; i++) send_item(PIXEL_ITEM, rand_pixel());
    repeat (4) send_item(FLUSH_ITEM, 8'd0);
    wait_idle();
  endtask

  task automatic test_random_frames(input int idle_pct, input int stall_v, input int n_items);
    int sent, w, h, cut, frame_len;
    bit fresh;
    send_idle_pct = idle_pct;
    stall_pct = stall_v;
    sent = 0;
    fresh = 1;
    w = 1;
    h = 1;
    while (sent < n_items) begin
      if (fresh || $urandom_range(99) < 70) begin
        wait_idle();
        cfg_write(REG_MASK, rand_mask());
        w = ($urandom_range(9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 40);
        h = $urandom_range(1, 5);
        cfg_write(REG_WIDTH, w);
        cfg_write(REG_HEIGHT, h);
      end
      frame_len = w * h + w + 1;
      // now and then break the frame off early
      cut = ($urandom_range(9) == 0) ? $urandom_range(1, frame_len - 1) : frame_len;
      if (cut > n_items - sent) cut = n_items - sent;
      fresh = (cut < frame_len);
      for (int i = 0; i < cut; i++) begin
        if (i < w * h)
          send_item(($urandom_range(99) < 3) ? FLUSH_ITEM : PIXEL_ITEM, rand_pixel());
        else
          send_item(($urandom_range(99) < 5) ? PIXEL_ITEM : FLUSH_ITEM, rand_pixel());
      end
      sent += cut;
    end
    wait_idle();
  endtask

  initial begin
    reset_filter_state();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_frames();
    test_backpressure();
    test_random_frames(0, 0, 260);
    test_random_frames(80, 0, 260);
    test_random_frames(0, 80, 260);
    test_random_frames(15, 15, 260);
    send_idle_pct = 0;
    stall_pct = 0;
    wait_idle();
    if (pending_medians.size() != 0) begin
      $display("%0d results never arrived", pending_medians.size());
      error_count += pending_medians.size();
    end
    if (error_count == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
design/mmf_pkg.sv
design/mmf_rank_select.sv
design/masked_median_filter_3x3_core.sv
design/mmf_checker.sv
test/tb_top.sv
